/* src/crc16fpr_pkg.sv */
// shared constants and controller/datapath interface types for the framed packet receiver
`default_nettype none

package crc16fpr_pkg;

   // payload buffer size and derived widths
   localparam int MAX_PAYLOAD = 64;
   localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
   localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

   // fixed field widths
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 2;
   localparam int CRC_W    = 16;

   // crc-16/arc, reflected form of polynomial 0x8005
   localparam logic [CRC_W-1:0] CRC_POLY_REFL = 16'hA001;

   // frame status codes
   localparam logic [STATUS_W-1:0] FRAME_GOOD     = 2'd0;
   localparam logic [STATUS_W-1:0] FRAME_CRC_ERR  = 2'd1;
   localparam logic [STATUS_W-1:0] FRAME_TOO_LONG = 2'd2;

   // commands from controller to datapath
   typedef struct packed {
      logic                ld_id;
      logic                ld_len;
      logic                ld_data;
      logic                ld_crc_lo;
      logic                start_replay;
      logic                emit_byte;
      logic                emit_status;
      logic [STATUS_W-1:0] status;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic sync1_hit;
      logic sync2_hit;
      logic byte_too_long;
      logic byte_zero;
      logic held_zero;
      logic data_done;
      logic crc_ok;
      logic replay_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

/* src/crc16_framed_packet_receiver.sv */
// top level of the framed packet receiver with crc-16/arc check
// latency: a status result is valid the cycle after the length or last crc byte request
// throughput: one byte request per cycle while receiving; the output register stalls
//   the length and final crc byte only while a result is still waiting
// replay: after a good frame, one payload result per cycle unless the output stalls
// reset: synchronous, returns to sync hunt, sync bytes to 0xAA/0x55; no buffer clearing
`default_nettype none

module crc16_framed_packet_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream: tdata = rx_byte[7:0]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   // result stream: tdata = payload_byte[7:0], byte_index[13:8], frame_id[21:14],
   //   frame_length[29:22], zero[31:30]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,
   // tuser = byte_valid[0], frame_status[2:1]
   output logic      [2:0]  rsp_tuser,
   output logic             rsp_tlast,
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   crc16fpr_pkg::dp_cmd_type    cmd;
   crc16fpr_pkg::dp_status_type sts;

   assign csr_pready = 1'b1;

   // sequencing
   crc16fpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath
   crc16fpr_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

`default_nettype wire

/* src/crc16fpr_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module crc16fpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/crc16fpr_ctrl.sv */
// frame parser state machine: sync hunt, header, payload, crc and replay sequencing
`default_nettype none

module crc16fpr_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire crc16fpr_pkg::dp_status_type sts,
   output crc16fpr_pkg::dp_cmd_type         cmd
);

   // state codes, hunting is the default branch of the case
   localparam logic [2:0] ST_HUNT   = 3'd0;
   localparam logic [2:0] ST_SYNC1  = 3'd1;
   localparam logic [2:0] ST_ID     = 3'd2;
   localparam logic [2:0] ST_LEN    = 3'd3;
   localparam logic [2:0] ST_DATA   = 3'd4;
   localparam logic [2:0] ST_CRCLO  = 3'd5;
   localparam logic [2:0] ST_CRCHI  = 3'd6;
   localparam logic [2:0] ST_REPLAY = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   // states that may emit a result need a free output slot
   assign req_tready = (state_ff == ST_REPLAY) ? 1'b0 :
                       ((state_ff inside {ST_LEN, ST_CRCHI}) ? sts.out_free : 1'b1);
   assign accept = req_tvalid && req_tready;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_SYNC1: begin
            if (accept) begin
               state_in = sts.sync2_hit ? ST_ID : ST_HUNT;
            end
         end
         ST_ID: begin
            if (accept) begin
               cmd.ld_id = 1'b1;
               state_in  = ST_LEN;
            end
         end
         ST_LEN: begin
            if (accept) begin
               cmd.ld_len = 1'b1;
               if (sts.byte_too_long) begin
                  cmd.emit_status = 1'b1;
                  cmd.status      = crc16fpr_pkg::FRAME_TOO_LONG;
                  state_in        = ST_HUNT;
               end else if (sts.byte_zero) begin
                  state_in = ST_CRCLO;
               end else begin
                  state_in = ST_DATA;
               end
            end
         end
         ST_DATA: begin
            if (accept) begin
               cmd.ld_data = 1'b1;
               if (sts.data_done) begin
                  state_in = ST_CRCLO;
               end
            end
         end
         ST_CRCLO: begin
            if (accept) begin
               cmd.ld_crc_lo = 1'b1;
               state_in      = ST_CRCHI;
            end
         end
         ST_CRCHI: begin
            if (accept) begin
               if (!sts.crc_ok) begin
                  cmd.emit_status = 1'b1;
                  cmd.status      = crc16fpr_pkg::FRAME_CRC_ERR;
                  state_in        = ST_HUNT;
               end else if (sts.held_zero) begin
                  cmd.emit_status = 1'b1;
                  cmd.status      = crc16fpr_pkg::FRAME_GOOD;
                  state_in        = ST_HUNT;
               end else begin
                  cmd.start_replay = 1'b1;
                  state_in         = ST_REPLAY;
               end
            end
         end
         ST_REPLAY: begin
            if (sts.out_free) begin
               cmd.emit_byte = 1'b1;
               if (sts.replay_last) begin
                  state_in = ST_HUNT;
               end
            end
         end
         default: begin
            if (accept) begin
               state_in = sts.sync1_hit ? ST_SYNC1 : ST_HUNT;
            end
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   // a result is only issued into a free output slot
   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_status || cmd.emit_byte) |-> sts.out_free)
      else $error("result issued while output register busy");

   // at most one datapath update per cycle
   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.ld_id, cmd.ld_len, cmd.ld_data, cmd.ld_crc_lo,
                cmd.start_replay, cmd.emit_byte}))
      else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

/* src/crc16fpr_dp.sv */
// receiver datapath: sync registers, header and crc registers, payload buffer, output register
`default_nettype none

module crc16fpr_dp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [7:0]                  req_tdata,
   input  wire logic                        rsp_tready,
   output logic                             rsp_tvalid,
   output logic      [31:0]                 rsp_tdata,
   output logic      [2:0]                  rsp_tuser,
   output logic                             rsp_tlast,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [2:0]                  csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output logic      [31:0]                 csr_prdata,
   input  wire crc16fpr_pkg::dp_cmd_type    cmd,
   output crc16fpr_pkg::dp_status_type      sts
);

   localparam int BW = crc16fpr_pkg::BYTE_W;

   // one byte through the reflected crc, eight shift steps
   function automatic logic [crc16fpr_pkg::CRC_W-1:0] crc_next(
      input logic [crc16fpr_pkg::CRC_W-1:0] crc_cur,
      input logic [BW-1:0]                  data
   );
      logic [crc16fpr_pkg::CRC_W-1:0] c;
      c = crc_cur ^ {{(crc16fpr_pkg::CRC_W - BW){1'b0}}, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ crc16fpr_pkg::CRC_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

   logic [BW-1:0]                     sync_first_ff;
   logic [BW-1:0]                     sync_second_ff;
   logic                              csr_wr;

   logic [BW-1:0]                     held_id_ff;
   logic [BW-1:0]                     held_length_ff;
   logic [crc16fpr_pkg::CNT_W-1:0]    count_ff;
   logic [crc16fpr_pkg::CRC_W-1:0]    crc_ff;
   logic [BW-1:0]                     crc_low_ff;
   logic [crc16fpr_pkg::ADDR_W-1:0]   idx_ff;
   logic [crc16fpr_pkg::ADDR_W-1:0]   idx_in;
   logic [BW-1:0]                     ram_rd_data;

   logic                              out_valid_ff;
   logic [BW-1:0]                     out_payload_ff;
   logic [crc16fpr_pkg::INDEX_W-1:0]  out_index_ff;
   logic                              out_byte_valid_ff;
   logic [BW-1:0]                     out_id_ff;
   logic [BW-1:0]                     out_length_ff;
   logic [crc16fpr_pkg::STATUS_W-1:0] out_status_ff;
   logic                              out_last_ff;
   logic                              out_load;

   // configuration registers, word address in bit 2
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= 8'hAA;
         sync_second_ff <= 8'h55;
      end else if (csr_wr) begin
         if (csr_paddr[2]) begin
            sync_second_ff <= csr_pwdata[BW-1:0];
         end else begin
            sync_first_ff <= csr_pwdata[BW-1:0];
         end
      end
   end

   assign csr_prdata = {24'd0, csr_paddr[2] ? sync_second_ff : sync_first_ff};

   // frame header, payload count and running crc
   always_ff @(posedge clock) begin
      if (cmd.ld_id) begin
         held_id_ff <= req_tdata;
      end
      if (cmd.ld_len) begin
         held_length_ff <= req_tdata;
         count_ff       <= '0;
         crc_ff         <= '0;
      end
      if (cmd.ld_data) begin
         count_ff <= count_ff + crc16fpr_pkg::CNT_W'(1);
         crc_ff   <= crc_next(crc_ff, req_tdata);
      end
      if (cmd.ld_crc_lo) begin
         crc_low_ff <= req_tdata;
      end
   end

   // replay index, read address follows the next index
   assign idx_in = cmd.start_replay ? '0 :
                   (cmd.emit_byte ? idx_ff + crc16fpr_pkg::ADDR_W'(1) : idx_ff);

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // payload buffer
   crc16fpr_ram #(
      .WIDTH (BW),
      .DEPTH (crc16fpr_pkg::MAX_PAYLOAD)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (cmd.ld_data),
      .wr_addr (count_ff[crc16fpr_pkg::ADDR_W-1:0]),
      .wr_data (req_tdata),
      .rd_addr (idx_in),
      .rd_data (ram_rd_data)
   );

   // status toward the controller
   always_comb begin
      sts.sync1_hit     = (req_tdata == sync_first_ff);
      sts.sync2_hit     = (req_tdata == sync_second_ff);
      sts.byte_too_long = (req_tdata > BW'(crc16fpr_pkg::MAX_PAYLOAD));
      sts.byte_zero     = (req_tdata == '0);
      sts.held_zero     = (held_length_ff == '0);
      sts.data_done     = ((BW'(count_ff) + BW'(1)) >= held_length_ff);
      sts.crc_ok        = ({req_tdata, crc_low_ff} == crc_ff);
      sts.replay_last   = ((BW'(idx_ff) + BW'(1)) == held_length_ff);
      sts.out_free      = !out_valid_ff || rsp_tready;
   end

   // output register
   assign out_load = cmd.emit_byte || cmd.emit_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_payload_ff    <= cmd.emit_byte ? ram_rd_data : '0;
         out_index_ff      <= cmd.emit_byte ? crc16fpr_pkg::INDEX_W'(idx_ff) : '0;
         out_byte_valid_ff <= cmd.emit_byte;
         out_id_ff         <= held_id_ff;
         out_length_ff     <= cmd.ld_len ? req_tdata : held_length_ff;
         out_status_ff     <= cmd.emit_byte ? crc16fpr_pkg::FRAME_GOOD : cmd.status;
         out_last_ff       <= cmd.emit_byte ? sts.replay_last : 1'b1;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_length_ff, out_id_ff, out_index_ff, out_payload_ff};
   assign rsp_tuser  = {out_status_ff, out_byte_valid_ff};
   assign rsp_tlast  = out_last_ff;

`ifndef NO_ASSERTIONS
   // payload writes stay inside the buffer
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.ld_data |-> (count_ff < crc16fpr_pkg::CNT_W'(crc16fpr_pkg::MAX_PAYLOAD)))
      else $error("payload write beyond buffer");

   // replay only runs for a buffered, non-empty frame
   a_replay_length: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_byte |-> (held_length_ff != '0 &&
                         held_length_ff <= BW'(crc16fpr_pkg::MAX_PAYLOAD)))
      else $error("replay with invalid frame length");
`endif

endmodule

`default_nettype wire

/* tb/crc16_framed_packet_receiver_tb.sv */
// self-checking testbench for the crc-16/arc framed packet receiver
`default_nettype none

module crc16_framed_packet_receiver_tb;

   // run limits and register map
   localparam int          CYCLE_LIMIT     = 400000;
   localparam int          DRAIN_CYCLES    = 16;
   localparam int          PHASE_BYTES     = 16;
   localparam int          DIRECTED_ROWS   = 27;
   localparam logic [2:0]  CSR_SYNC_FIRST  = 3'd0;
   localparam logic [2:0]  CSR_SYNC_SECOND = 3'd4;
   // reflected form of polynomial 0x8005
   localparam logic [15:0] CRC16_ARC_REFL  = 16'hA001;

   typedef enum logic [2:0] {
      RX_HUNT, RX_SYNC2, RX_ID, RX_LEN, RX_DATA, RX_CRC
   } rx_phase_type;

   typedef enum logic [1:0] { ROW_LIT, ROW_FCS_LO, ROW_FCS_HI } row_kind_type;

   typedef struct packed {
      logic [7:0]                        payload;
      logic [5:0]                        index;
      logic                              valid;
      logic [7:0]                        id;
      logic [7:0]                        length;
      logic [crc16fpr_pkg::STATUS_W-1:0] status;
      logic                              last;
   } frame_result_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [7:0]       value;
      logic             typed;
      frame_result_type result;
   } stim_row_type;

   localparam frame_result_type NO_RESULT = '0;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   wire         req_tready;
   logic [7:0]  req_tdata   = 8'h00;
   wire         rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   wire  [31:0] rsp_tdata;
   wire  [2:0]  rsp_tuser;
   wire         rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = 3'd0;
   logic [31:0] csr_pwdata  = 32'h0;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   crc16_framed_packet_receiver dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // parser mirror state
   rx_phase_type rx_phase;
   logic [7:0]   cfg_sync_first;
   logic [7:0]   cfg_sync_second;
   logic [7:0]   frame_id_q;
   logic [7:0]   frame_len_q;
   int           data_count;
   logic [15:0]  crc_acc;
   logic [7:0]   crc_lo_q;
   logic         crc_half;
   logic [7:0]   payload_mem [crc16fpr_pkg::MAX_PAYLOAD];

   frame_result_type awaited_results [$];
   frame_result_type fresh_results [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int good_frames   = 0;
   int crc_errors    = 0;
   int oversize      = 0;
   int mismatches    = 0;
   int cycle_count   = 0;

   // directed requests; typed results stand where they are obvious
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // empty frame with zero crc, id and length at their low extreme
      '{ROW_LIT, 8'hAA, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'h55, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'h00, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'h00, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'h00, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'h00, 1'b1,
        '{8'h00, 6'd0, 1'b0, 8'h00, 8'h00, crc16fpr_pkg::FRAME_GOOD, 1'b1}},
      // length one above the buffer, id at its high extreme
      '{ROW_LIT, 8'hAA, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'h55, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'hFF, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'h41, 1'b1,
        '{8'h00, 6'd0, 1'b0, 8'hFF, 8'h41, crc16fpr_pkg::FRAME_TOO_LONG, 1'b1}},
      // wrong second sync, the failing byte must not restart the hunt
      '{ROW_LIT, 8'hAA, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'hAA, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'h55, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'h00, 1'b0, NO_RESULT},
      // empty frame with a nonzero crc
      '{ROW_LIT, 8'hAA, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'h55, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'h22, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'h00, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'h01, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'h00, 1'b1,
        '{8'h00, 6'd0, 1'b0, 8'h22, 8'h00, crc16fpr_pkg::FRAME_CRC_ERR, 1'b1}},
      // one byte payload with a good crc
      '{ROW_LIT, 8'hAA, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'h55, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'h33, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'h01, 1'b0, NO_RESULT},
      '{ROW_LIT, 8'hFF, 1'b0, NO_RESULT},
      '{ROW_FCS_LO, 8'h00, 1'b0, NO_RESULT},
      '{ROW_FCS_HI, 8'h00, 1'b0, NO_RESULT}
   };

   function automatic logic [15:0] crc16_arc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] acc;
      acc = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++)
         acc = acc[0] ? ((acc >> 1) ^ CRC16_ARC_REFL) : (acc >> 1);
      return acc;
   endfunction

   function automatic frame_result_type status_result(
      input logic [crc16fpr_pkg::STATUS_W-1:0] status
   );
      return '{8'h00, 6'd0, 1'b0, frame_id_q, frame_len_q, status, 1'b1};
   endfunction

   task automatic clear_parser();
      rx_phase        = RX_HUNT;
      cfg_sync_first  = 8'hAA;
      cfg_sync_second = 8'h55;
      frame_id_q      = 8'h00;
      frame_len_q     = 8'h00;
      data_count      = 0;
      crc_acc         = 16'h0000;
      crc_lo_q        = 8'h00;
      crc_half        = 1'b0;
   endtask

   // advance the parser by one received byte, collecting the results it causes
   task automatic parse_rx_byte(input logic [7:0] b);
      fresh_results.delete();
      case (rx_phase)
         RX_SYNC2: begin
            if (b == cfg_sync_second) begin
               data_count = 0;
               rx_phase   = RX_ID;
            end else begin
               rx_phase = RX_HUNT;
            end
         end
         RX_ID: begin
            frame_id_q = b;
            rx_phase   = RX_LEN;
         end
         RX_LEN: begin
            frame_len_q = b;
            data_count  = 0;
            crc_acc     = 16'h0000;
            crc_half    = 1'b0;
            if (b > crc16fpr_pkg::MAX_PAYLOAD) begin
               fresh_results.push_back(status_result(crc16fpr_pkg::FRAME_TOO_LONG));
               rx_phase = RX_HUNT;
            end else if (b == 8'h00) begin
               rx_phase = RX_CRC;
            end else begin
               rx_phase = RX_DATA;
            end
         end
         RX_DATA: begin
            payload_mem[data_count] = b;
            crc_acc    = crc16_arc_step(crc_acc, b);
            data_count = data_count + 1;
            if (data_count >= frame_len_q) begin
               crc_half = 1'b0;
               rx_phase = RX_CRC;
            end
         end
         RX_CRC: begin
            if (!crc_half) begin
               crc_lo_q = b;
               crc_half = 1'b1;
            end else begin
               crc_half = 1'b0;
               rx_phase = RX_HUNT;
               if ({b, crc_lo_q} != crc_acc)
                  fresh_results.push_back(status_result(crc16fpr_pkg::FRAME_CRC_ERR));
               else if (frame_len_q == 8'h00)
                  fresh_results.push_back(status_result(crc16fpr_pkg::FRAME_GOOD));
               else
                  for (int i = 0; i < frame_len_q; i++)
                     fresh_results.push_back(frame_result_type'{payload_mem[i], 6'(i), 1'b1,
                        frame_id_q, frame_len_q, crc16fpr_pkg::FRAME_GOOD,
                        (i + 1 == frame_len_q)});
            end
         end
         default: rx_phase = (b == cfg_sync_first) ? RX_SYNC2 : RX_HUNT;
      endcase
   endtask

   // one request with random hold-off; typed rows replace the parser's results
   task automatic send_rx_byte(input logic [7:0] value, input logic typed,
                               input frame_result_type typed_result);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      parse_rx_byte(value);
      if (typed)
         awaited_results.push_back(typed_result);
      else
         foreach (fresh_results[i]) awaited_results.push_back(fresh_results[i]);
      items_sent = items_sent + 1;
   endtask

   task automatic send_plain(input logic [7:0] value);
      send_rx_byte(value, 1'b0, NO_RESULT);
   endtask

   // hold off requests until every pending result has come back
   task automatic wait_for_drain(input int extra);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // setup and access cycle; upper data bits are junk the block must mask
   task automatic write_sync_reg(input logic [2:0] addr, input logic [7:0] value);
      logic [31:0] junk;
      junk        = $urandom;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {junk[31:8], value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (addr == CSR_SYNC_FIRST)
         cfg_sync_first = value;
      else if (addr == CSR_SYNC_SECOND)
         cfg_sync_second = value;
   endtask

   // mostly well-formed frames, some noise, broken headers, oversize lengths and bad crcs
   task automatic send_random_frame(input logic max_length);
      logic [7:0]  len;
      logic [15:0] fcs;
      int          pick;
      pick = $urandom_range(99);
      if (!max_length && pick < 15) begin
         case ($urandom_range(2))
            0: repeat ($urandom_range(3, 1)) send_plain(8'($urandom));
            1: begin
               send_plain(cfg_sync_first);
               send_plain(cfg_sync_second ^ 8'($urandom_range(255, 1)));
            end
            default: begin
               // header and a cut-off payload
               len = 8'($urandom_range(8, 1));
               send_plain(cfg_sync_first);
               send_plain(cfg_sync_second);
               send_plain(8'($urandom));
               send_plain(len);
               repeat ($urandom_range(len - 1)) send_plain(8'($urandom));
            end
         endcase
      end else begin
         if (max_length)
            len = 8'(crc16fpr_pkg::MAX_PAYLOAD);
         else if (pick < 25)
            len = ($urandom_range(3) == 0) ? 8'hFF :
                  8'($urandom_range(255, crc16fpr_pkg::MAX_PAYLOAD + 1));
         else if (pick < 27)
            len = 8'($urandom_range(crc16fpr_pkg::MAX_PAYLOAD,
                                    crc16fpr_pkg::MAX_PAYLOAD - 1));
         else
            len = 8'($urandom_range(8));
         send_plain(cfg_sync_first);
         send_plain(cfg_sync_second);
         send_plain(8'($urandom));
         send_plain(len);
         if (len <= crc16fpr_pkg::MAX_PAYLOAD) begin
            repeat (len) send_plain(8'($urandom));
            fcs = crc_acc;
            if (pick >= 27 && pick < 39)
               fcs = fcs ^ 16'($urandom_range(16'hFFFF, 1));
            send_plain(fcs[7:0]);
            send_plain(fcs[15:8]);
         end
      end
   endtask

   task automatic flag_field(input string field, input logic [7:0] want, input logic [7:0] got);
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, field, want, got);
      mismatches = mismatches + 1;
   endtask

   // result side: random stalls and in-order compare
   always @(posedge clock) begin : result_check
      frame_result_type got;
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[7:0], rsp_tdata[13:8], rsp_tuser[0], rsp_tdata[21:14],
                rsp_tdata[29:22], rsp_tuser[2:1], rsp_tlast};
         results_seen = results_seen + 1;
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result expected none got 0x%0h", $time, got);
            mismatches = mismatches + 1;
         end else begin
            want = awaited_results.pop_front();
            if (got.payload !== want.payload)
               flag_field("payload_byte", want.payload, got.payload);
            if (got.index !== want.index)
               flag_field("byte_index", 8'(want.index), 8'(got.index));
            if (got.valid !== want.valid)
               flag_field("byte_valid", 8'(want.valid), 8'(got.valid));
            if (got.id !== want.id)
               flag_field("frame_id", want.id, got.id);
            if (got.length !== want.length)
               flag_field("frame_length", want.length, got.length);
            if (got.status !== want.status)
               flag_field("frame_status", 8'(want.status), 8'(got.status));
            if (got.last !== want.last)
               flag_field("last", 8'(want.last), 8'(got.last));
            if (want.last && want.status == crc16fpr_pkg::FRAME_GOOD)
               good_frames = good_frames + 1;
            if (want.status == crc16fpr_pkg::FRAME_CRC_ERR) crc_errors = crc_errors + 1;
            if (want.status == crc16fpr_pkg::FRAME_TOO_LONG) oversize = oversize + 1;
         end
      end
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  awaited_results.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      logic [7:0] value;
      logic [7:0] pick_first;
      logic [7:0] pick_second;
      int         frames;
      int         phase_start;
      clear_parser();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed rows at reset settings, no idling
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         case (directed_rows[r].kind)
            ROW_FCS_LO: value = crc_acc[7:0];
            ROW_FCS_HI: value = crc_acc[15:8];
            default:    value = directed_rows[r].value;
         endcase
         send_rx_byte(value, directed_rows[r].typed, directed_rows[r].result);
      end

      // random phases, each with its own sync bytes and idling mix
      for (int ph = 0; ph < 4; ph++) begin
         wait_for_drain(DRAIN_CYCLES);
         case (ph)
            0: begin pick_first = 8'h00; pick_second = 8'hFF; end
            1: begin pick_first = 8'hFF; pick_second = 8'h00; end
            2: begin pick_first = 8'($urandom); pick_second = 8'($urandom); end
            default: begin pick_first = 8'($urandom); pick_second = pick_first; end
         endcase
         write_sync_reg(CSR_SYNC_FIRST, pick_first);
         write_sync_reg(CSR_SYNC_SECOND, pick_second);
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 81; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 81; end
            default: begin send_idle_pct = 35; rsp_stall_pct = 35; end
         endcase
         frames      = 0;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_BYTES) begin
            send_random_frame(frames == 0 && ph == 0);
            frames = frames + 1;
            // full pause mid-phase
            if (frames == 2) wait_for_drain(0);
         end
      end

      wait_for_drain(DRAIN_CYCLES);
      $display("sent %0d request bytes over four sync settings and idling mixes", items_sent);
      $display("checked %0d results: %0d good frames, %0d crc errors, %0d oversize",
               results_seen, good_frames, crc_errors, oversize);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
